>>> hw/rtl/lnae_pkg.sv
// package: shared types, constants and helper functions of the lattice embedder
`timescale 1ns / 1ps
package lnae_pkg;

    typedef logic signed [14:0] t_crd;

    localparam int   PIX_W       = 24;
    localparam int   SUM_W       = 11;
    localparam int   CNT_W       = 4;
    localparam int   RCP_W       = 17;
    localparam int   RCP_SHIFT   = 16;
    localparam int   CFG_IDX_W   = 2;
    localparam int   CFG_DATA_W  = 13;
    localparam int   NB_NUM      = 9;
    localparam t_crd STRIP_LEN   = t_crd'(7 + 6 * 15);
    localparam t_crd MAX_HEIGHT  = t_crd'(4096);
    localparam t_crd WIDTH_RST   = t_crd'(640);
    localparam t_crd HEIGHT_RST  = t_crd'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT,
        S_SETUP,
        S_READ,
        S_DIV,
        S_OUT
    } t_state;

    function automatic logic guarded(input t_crd r, input t_crd c, input t_crd w,
                                     input t_crd h, input t_crd sw, input t_crd sh);
        logic g;
        g = 1'b0;
        if (c >= w - sw && r >= h - sh) g = 1'b1;
        if (c >= w - STRIP_LEN && r >= h - t_crd'(2)) g = 1'b1;
        if (c >= w - t_crd'(2) && r >= h - STRIP_LEN) g = 1'b1;
        return g;
    endfunction

    // residue mod 3 by folding base-4 digits
    function automatic logic [1:0] mod3(input logic [13:0] v);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int k = 0; k < 7; k++) begin
            s1 = s1 + 5'(v[2*k +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        if (s3 >= 3'd3) s3 = s3 - 3'd3;
        return s3[1:0];
    endfunction

    // ceil(2^16 / n), exact floor division for sums up to 2040
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RCP_W-1:0] m;
        unique case (n)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

    // neighbour offsets: center, left 1/2, right 1/2, up 1/2, down 1/2
    function automatic t_crd nb_drow(input logic [CNT_W-1:0] idx);
        t_crd d;
        unique case (idx)
            4'd5:    d = -t_crd'(1);
            4'd6:    d = -t_crd'(2);
            4'd7:    d = t_crd'(1);
            4'd8:    d = t_crd'(2);
            default: d = t_crd'(0);
        endcase
        return d;
    endfunction

    function automatic t_crd nb_dcol(input logic [CNT_W-1:0] idx);
        t_crd d;
        unique case (idx)
            4'd1:    d = -t_crd'(1);
            4'd2:    d = -t_crd'(2);
            4'd3:    d = t_crd'(1);
            4'd4:    d = t_crd'(2);
            default: d = t_crd'(0);
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/lnae_ifs.sv
// interfaces: pixel request, result request and configuration write channels
`timescale 1ns / 1ps
interface lnae_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface lnae_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        replaced;
    logic        last_of_run;
    modport source (output valid, out_row, out_col, out_red, out_green, out_blue,
                    replaced, last_of_run, input ready);
    modport sink (input valid, out_row, out_col, out_red, out_green, out_blue,
                  replaced, last_of_run, output ready);
endinterface

interface lnae_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lnae_line_mem.sv
// line memory: four rows of pixels, one write and one registered read port
`timescale 1ns / 1ps
module lnae_line_mem import lnae_pkg::*; #(
    parameter int AW = 13
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);
    logic [PIX_W-1:0] r_mem [2**AW];
    logic [PIX_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

>>> hw/rtl/lnae_avg_div.sv
// neighbour average: per-channel sum times reciprocal of the count
`timescale 1ns / 1ps
module lnae_avg_div import lnae_pkg::*; (
    input  logic             i_clk,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_sum_r,
    input  logic [SUM_W-1:0] i_sum_g,
    input  logic [SUM_W-1:0] i_sum_b,
    input  logic [CNT_W-1:0] i_cnt,
    output logic [PIX_W-1:0] o_avg
);
    localparam int PW = SUM_W + RCP_W;

    logic [PW-1:0]    r_prod_r;
    logic [PW-1:0]    r_prod_g;
    logic [PW-1:0]    r_prod_b;
    logic [RCP_W-1:0] rcp;

    assign rcp = recip(i_cnt);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod_r <= PW'(i_sum_r) * PW'(rcp);
            r_prod_g <= PW'(i_sum_g) * PW'(rcp);
            r_prod_b <= PW'(i_sum_b) * PW'(rcp);
        end
    end

    assign o_avg = {r_prod_b[RCP_SHIFT +: 8], r_prod_g[RCP_SHIFT +: 8],
                    r_prod_r[RCP_SHIFT +: 8]};
endmodule

>>> hw/rtl/lattice_neighbour_average_embed.sv
// top level: raster sequencer, neighbour gather and result register
`timescale 1ns / 1ps
// Takes RGB pixels in raster order and emits each one with its row and column, two rows
// late; pixels on the mod-3 diagonal lattice outside the protected lower-right corner are
// replaced by the truncated mean of up to eight neighbours. Each released result makes nine
// reads through the single read port of the four-line memory, and the sequencer waits while
// the result register is still held for the receiver. The last row releases up to five
// results per pixel. Writing either size register restarts the frame at row 0, column 0.
// The line memory needs no clearing after reset.
module lattice_neighbour_average_embed import lnae_pkg::*; #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SIGN_WIDTH  = 38,
    parameter int SIGN_HEIGHT = 34
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lnae_pix_if.sink   i_pix,
    lnae_res_if.source o_res,
    lnae_cfg_if.sink   i_cfg
);
    localparam int   CW = $clog2(MAX_WIDTH);
    localparam int   AW = CW + 2;
    localparam t_crd MW = t_crd'(MAX_WIDTH);
    localparam t_crd SW = t_crd'(SIGN_WIDTH);
    localparam t_crd SH = t_crd'(SIGN_HEIGHT);

    t_state r_state, n_state;

    t_crd             r_w, r_h;
    logic [11:0]      r_row;
    logic [CW-1:0]    r_col;
    logic [PIX_W-1:0] r_pix;
    t_crd             r_jr, r_jc;
    logic [4:0]       r_slots;
    logic             r_wrote;
    t_crd             r_p, r_c;
    logic             r_last;
    logic             r_rep_ok;
    logic [NB_NUM-1:0] r_nmask;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_rd_ovr;
    logic [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [PIX_W-1:0] r_center;

    logic             r_ov;
    logic [11:0]      r_o_row;
    logic [10:0]      r_o_col;
    logic [PIX_W-1:0] r_o_pix;
    logic             r_o_rep;
    logic             r_o_last;

    logic             cfg_wr, pix_acc, out_load;
    t_crd             cfg_w, cfg_h;
    t_crd             jr, jc;
    logic [4:0]       acc_slots;
    logic [4:0]       pick_oh, remain;
    logic             pick_go, do_write;
    t_crd             pick_p, pick_c;
    logic             self_g, match;
    logic [NB_NUM-1:0] nmask;
    logic [CNT_W-1:0] ncnt;
    t_crd             nr, nc;
    logic             ovr;
    logic [PIX_W-1:0] rd_q, rd_v, avg;
    logic [AW-1:0]    raddr, waddr;
    logic             div_start;

    // configuration
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_comb begin
        cfg_w = t_crd'(i_cfg.data[11:0]);
        if (cfg_w < t_crd'(1)) cfg_w = t_crd'(1);
        if (cfg_w > MW) cfg_w = MW;
        cfg_h = t_crd'(i_cfg.data);
        if (cfg_h < t_crd'(1)) cfg_h = t_crd'(1);
        if (cfg_h > MAX_HEIGHT) cfg_h = MAX_HEIGHT;
    end

    // position of the accepted pixel and results it releases
    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    always_comb begin
        logic lastrow;
        if (t_crd'(r_col) >= r_w || t_crd'(r_row) >= r_h) begin
            jr = '0;
            jc = '0;
        end else begin
            jr = t_crd'(r_row);
            jc = t_crd'(r_col);
        end
        lastrow      = (jr == r_h - t_crd'(1));
        acc_slots[0] = jr >= t_crd'(2);
        acc_slots[1] = lastrow && jr >= t_crd'(1);
        acc_slots[2] = lastrow && jc >= t_crd'(2);
        acc_slots[3] = lastrow && jc == r_w - t_crd'(1) && r_w >= t_crd'(2);
        acc_slots[4] = lastrow && jc == r_w - t_crd'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= WIDTH_RST;
            r_h   <= HEIGHT_RST;
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_wr) begin
            if (i_cfg.index == CFG_FRAME_WIDTH) begin
                r_w   <= cfg_w;
                r_row <= '0;
                r_col <= '0;
            end else if (i_cfg.index == CFG_FRAME_HEIGHT) begin
                r_h   <= cfg_h;
                r_row <= '0;
                r_col <= '0;
            end
        end else if (pix_acc) begin
            if (jc + t_crd'(1) >= r_w) begin
                r_col <= '0;
                if (jr + t_crd'(1) >= r_h) begin
                    r_row <= '0;
                end else begin
                    r_row <= 12'(jr + t_crd'(1));
                end
            end else begin
                r_col <= CW'(jc + t_crd'(1));
            end
        end
    end

    // slot selection: oldest-row result first, then line write, then last-row results
    assign pick_oh = r_slots & (~r_slots + 5'd1);
    assign remain  = r_slots & ~pick_oh;
    assign pick_go = r_slots[0] || (r_wrote && r_slots != '0);

    always_comb begin
        priority if (pick_oh[0]) begin
            pick_p = r_jr - t_crd'(2);
            pick_c = r_jc;
        end else if (pick_oh[1]) begin
            pick_p = r_jr - t_crd'(1);
            pick_c = r_jc;
        end else if (pick_oh[2]) begin
            pick_p = r_jr;
            pick_c = r_jc - t_crd'(2);
        end else if (pick_oh[3]) begin
            pick_p = r_jr;
            pick_c = r_w - t_crd'(2);
        end else begin
            pick_p = r_jr;
            pick_c = r_w - t_crd'(1);
        end
    end

    // neighbour set of the pixel being emitted
    always_comb begin
        self_g   = guarded(r_p, r_c, r_w, r_h, SW, SH);
        match    = mod3(r_p[13:0]) == mod3(r_c[13:0]);
        nmask[0] = 1'b1;
        nmask[1] = r_c >= t_crd'(1);
        nmask[2] = r_c >= t_crd'(2);
        nmask[3] = r_c < r_w - t_crd'(1) &&
                   !guarded(r_p, r_c + t_crd'(1), r_w, r_h, SW, SH);
        nmask[4] = r_c < r_w - t_crd'(2) &&
                   !guarded(r_p, r_c + t_crd'(2), r_w, r_h, SW, SH);
        nmask[5] = r_p >= t_crd'(1);
        nmask[6] = r_p >= t_crd'(2);
        nmask[7] = r_p < r_h - t_crd'(1) &&
                   !guarded(r_p + t_crd'(1), r_c, r_w, r_h, SW, SH);
        nmask[8] = r_p < r_h - t_crd'(2) &&
                   !guarded(r_p + t_crd'(2), r_c, r_w, r_h, SW, SH);
        ncnt = '0;
        for (int k = 1; k < NB_NUM; k++) begin
            ncnt = ncnt + CNT_W'(nmask[k]);
        end
    end

    // memory access
    assign nr    = r_p + nb_drow(r_idx);
    assign nc    = r_c + nb_dcol(r_idx);
    assign ovr   = (nr == r_jr) && (nc == r_jc);
    assign raddr = {nr[1:0], nc[CW-1:0]};
    assign waddr = {r_jr[1:0], r_jc[CW-1:0]};
    assign rd_v  = r_rd_ovr ? r_pix : rd_q;

    lnae_line_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (waddr),
        .i_wdata (r_pix),
        .i_raddr (raddr),
        .o_rdata (rd_q)
    );

    lnae_avg_div u_div (
        .i_clk   (i_clk),
        .i_start (div_start),
        .i_sum_r (r_sum_r),
        .i_sum_g (r_sum_g),
        .i_sum_b (r_sum_b),
        .i_cnt   (r_cnt),
        .o_avg   (avg)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        do_write  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (pix_acc) n_state = S_SLOT;
            end
            S_SLOT: begin
                priority if (pick_go) begin
                    n_state = S_SETUP;
                end else if (!r_wrote) begin
                    do_write = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SETUP: begin
                n_state = S_READ;
            end
            S_READ: begin
                if (r_idx == CNT_W'(NB_NUM)) n_state = S_DIV;
            end
            S_DIV: begin
                div_start = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = S_SLOT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
            r_wrote <= 1'b0;
        end else if (pix_acc) begin
            r_slots <= acc_slots;
            r_wrote <= 1'b0;
        end else if (r_state == S_SLOT) begin
            if (pick_go) begin
                r_slots <= remain;
            end else if (!r_wrote) begin
                r_wrote <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_pix <= {i_pix.in_blue, i_pix.in_green, i_pix.in_red};
            r_jr  <= jr;
            r_jc  <= jc;
        end
        if (r_state == S_SLOT && pick_go) begin
            r_p    <= pick_p;
            r_c    <= pick_c;
            r_last <= (remain == '0);
        end
        if (r_state == S_SETUP) begin
            r_rep_ok <= match && !self_g;
            r_nmask  <= nmask;
            r_cnt    <= ncnt;
            r_idx    <= '0;
            r_sum_r  <= '0;
            r_sum_g  <= '0;
            r_sum_b  <= '0;
        end
        if (r_state == S_READ) begin
            r_idx    <= r_idx + CNT_W'(1);
            r_rd_idx <= r_idx;
            r_rd_ovr <= ovr;
            if (r_idx != '0) begin
                if (r_rd_idx == '0) begin
                    r_center <= rd_v;
                end else if (r_nmask[r_rd_idx]) begin
                    r_sum_r <= r_sum_r + SUM_W'(rd_v[7:0]);
                    r_sum_g <= r_sum_g + SUM_W'(rd_v[15:8]);
                    r_sum_b <= r_sum_b + SUM_W'(rd_v[23:16]);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_row  <= r_p[11:0];
            r_o_col  <= r_c[10:0];
            r_o_rep  <= r_rep_ok && r_cnt != '0;
            r_o_pix  <= (r_rep_ok && r_cnt != '0) ? avg : r_center;
            r_o_last <= r_last;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.out_row     = r_o_row;
    assign o_res.out_col     = r_o_col;
    assign o_res.out_red     = r_o_pix[7:0];
    assign o_res.out_green   = r_o_pix[15:8];
    assign o_res.out_blue    = r_o_pix[23:16];
    assign o_res.replaced    = r_o_rep;
    assign o_res.last_of_run = r_o_last;
endmodule
